// ===== rtl/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the triangle cell grid rasteriser:
// coordinate widths, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	// coordinates, quotients and edge-function operands, signed
	localparam int CW = 36;
	// products of two coordinates, signed Q42.32
	localparam int PW = 74;

	localparam logic [2:0] REG_EDGE   = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ORG_X  = 3'd2;
	localparam logic [2:0] REG_ORG_Y  = 3'd3;
	localparam logic [2:0] REG_GRID_W = 3'd4;
	localparam logic [2:0] REG_GRID_H = 3'd5;

	localparam logic [1:0] ORIENT_UP   = 2'd1;
	localparam logic [1:0] ORIENT_DOWN = 2'd2;

	// divider operand and result slot
	localparam logic [1:0] DSEL_XA = 2'd0;
	localparam logic [1:0] DSEL_XB = 2'd1;
	localparam logic [1:0] DSEL_YA = 2'd2;
	localparam logic [1:0] DSEL_YC = 2'd3;

	// edge being tested: start and end corner
	localparam logic [1:0] EDGE_BA = 2'd0;
	localparam logic [1:0] EDGE_CB = 2'd1;
	localparam logic [1:0] EDGE_AC = 2'd2;

	typedef enum logic [1:0] {
		MOP_PX,
		MOP_PY,
		MOP_E1,
		MOP_E2
	} mop_t;

	typedef struct packed {
		logic       capture;
		logic       div_go;
		logic [1:0] div_sel;
		logic       mul_go;
		mop_t       mul_op;
		logic [1:0] edge_sel;
		logic       cell_init;
		logic       jo;
		logic       ko;
		logic       push;
		logic       flush;
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic div_done;
		logic mul_done;
		logic jspan;
		logic kspan;
		logic hit;
	} stat_t;

endpackage

// ===== rtl/triangle_cell_grid_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_cell_grid_rasterizer
// Scans the grid cells under one equilateral triangle and reports each
// covered cell with the triangle's payload.
// ----------------------------------------------------------------------------
// A triangle is taken when start is high and busy low; busy falls in the
// cycle in which the final result of the triangle is on the result ports.
// Per triangle the sequencer runs four bounding-box quotients from a
// one-bit-a-cycle divider, then two products for the first cell corner
// and six products for each scanned cell from a multiplier that takes a
// 9-bit digit a cycle, all products through the one shared multiplier. A triangle with
// an orientation other than up or down, or with a zero edge length, is
// dropped after the check with no scan and no result.
// Results appear for one cycle each on valid and must be taken then; the
// final covered cell of a triangle carries last, and a triangle with no
// covered cell gives nothing. Registers may be written only while busy is low.
module triangle_cell_grid_rasterizer #(
	parameter int MAX_COLS = 4096,
	parameter int MAX_ROWS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] x_pos,
	input  logic signed [31:0] y_pos,
	input  logic [1:0]         orientation,
	input  logic [31:0]        euler_a,
	input  logic [31:0]        euler_b,
	input  logic [31:0]        euler_c,
	input  logic [31:0]        confidence,
	input  logic               quality_good,
	output logic               valid,
	output logic [23:0]        cell_index,
	output logic [11:0]        column,
	output logic [11:0]        row,
	output logic [31:0]        out_euler_a,
	output logic [31:0]        out_euler_b,
	output logic [31:0]        out_euler_c,
	output logic [31:0]        out_confidence,
	output logic               out_quality,
	output logic               last
);
	import tcgr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	tcgr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	tcgr_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.x_pos          (x_pos),
		.y_pos          (y_pos),
		.orientation    (orientation),
		.euler_a        (euler_a),
		.euler_b        (euler_b),
		.euler_c        (euler_c),
		.confidence     (confidence),
		.quality_good   (quality_good),
		.valid          (valid),
		.cell_index     (cell_index),
		.column         (column),
		.row            (row),
		.out_euler_a    (out_euler_a),
		.out_euler_b    (out_euler_b),
		.out_euler_c    (out_euler_c),
		.out_confidence (out_confidence),
		.out_quality    (out_quality),
		.last           (last)
	);

endmodule

// ===== rtl/tcgr_div.sv =====
// ----------------------------------------------------------------------------
// tcgr_div
// Restoring divider, one quotient bit a cycle, signed dividend by unsigned
// divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tcgr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic signed [tcgr_pkg::CW-1:0] num,
	input  logic [31:0]                   den,
	output logic                          done,
	output logic signed [tcgr_pkg::CW-1:0] quo
);
	import tcgr_pkg::*;

	localparam int NB = 34;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [NB-1:0] num_q;
	logic [NB-1:0] quo_q;
	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic          neg_q;

	logic [CW-1:0] mag;
	logic [32:0]   trial;
	logic [32:0]   diff;
	logic          ge;

	assign mag   = num[CW-1] ? CW'(-num) : CW'(num);
	assign trial = {rem_q, num_q[NB-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= mag[NB-1:0];
			den_q <= den;
			neg_q <= num[CW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			num_q <= {num_q[NB-2:0], 1'b0};
			quo_q <= {quo_q[NB-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

endmodule

// ===== rtl/tcgr_mul.sv =====
// ----------------------------------------------------------------------------
// tcgr_mul
// Signed multiplier over magnitudes, one 9-bit digit of the second operand
// a cycle, most significant digit first.
// ----------------------------------------------------------------------------
module tcgr_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic signed [tcgr_pkg::CW-1:0] a,
	input  logic signed [tcgr_pkg::CW-1:0] b,
	output logic                          done,
	output logic signed [tcgr_pkg::PW-1:0] p
);
	import tcgr_pkg::*;

	localparam int DG = 9;
	localparam int ND = CW / DG;
	localparam int AW = 2 * CW;

	logic          busy_q;
	logic          done_q;
	logic [2:0]    cnt_q;
	logic [CW-1:0] am_q;
	logic [CW-1:0] bm_q;
	logic [AW-1:0] acc_q;
	logic          neg_q;

	logic [CW-1:0]    am;
	logic [CW-1:0]    bm;
	logic [CW+DG-1:0] part;

	assign am   = a[CW-1] ? CW'(-a) : CW'(a);
	assign bm   = b[CW-1] ? CW'(-b) : CW'(b);
	assign part = am_q * bm_q[CW-1 -: DG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'(ND);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			am_q  <= am;
			bm_q  <= bm;
			neg_q <= a[CW-1] ^ b[CW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[AW-DG-1:0], {DG{1'b0}}} + AW'(part);
			bm_q  <= {bm_q[CW-DG-1:0], {DG{1'b0}}};
		end
	end

	assign done = done_q;
	assign p    = neg_q ? -$signed({2'b00, acc_q}) : $signed({2'b00, acc_q});

endmodule

// ===== rtl/tcgr_dp.sv =====
// ----------------------------------------------------------------------------
// tcgr_dp
// Datapath: configuration registers, triangle corners, divider and
// multiplier, edge-function signs, grid bounds and the result registers.
// ----------------------------------------------------------------------------
module tcgr_dp #(
	parameter int MAX_COLS = 4096,
	parameter int MAX_ROWS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcgr_pkg::cmd_t      cmd,
	output tcgr_pkg::stat_t     stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic signed [31:0]  x_pos,
	input  logic signed [31:0]  y_pos,
	input  logic [1:0]          orientation,
	input  logic [31:0]         euler_a,
	input  logic [31:0]         euler_b,
	input  logic [31:0]         euler_c,
	input  logic [31:0]         confidence,
	input  logic                quality_good,
	output logic                valid,
	output logic [23:0]         cell_index,
	output logic [11:0]         column,
	output logic [11:0]         row,
	output logic [31:0]         out_euler_a,
	output logic [31:0]         out_euler_b,
	output logic [31:0]         out_euler_c,
	output logic [31:0]         out_confidence,
	output logic                out_quality,
	output logic                last
);
	import tcgr_pkg::*;

	logic [31:0] len_q, hgt_q, ox_q, oy_q;
	logic [12:0] gw_q, gh_q;

	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic signed [CW-1:0] j0_q, j1_q, k0_q, k1_q;
	logic signed [CW-1:0] px0_q, py0_q, px_q, py_q, col_q, row_q;
	logic signed [PW-1:0] p1_q;
	logic                 ok_q, pos_q, neg_q;
	logic [31:0]          ea_q, eb_q, ec_q, conf_q;
	logic                 qual_q;

	logic        pend_v_q;
	logic [23:0] pend_idx_q;
	logic [11:0] pend_col_q, pend_row_q;

	logic                 valid_q, last_q;
	logic [23:0]          idx_q;
	logic [11:0]          col_out_q, row_out_q;

	logic signed [CW-1:0] len36, hgt36, half36, xa, y0;
	logic signed [CW-1:0] div_num, div_quo;
	logic                 div_done;
	logic signed [CW-1:0] mul_a, mul_b;
	logic signed [CW-1:0] ux, uy, vx, vy;
	logic signed [PW-1:0] mul_p, d, nd;
	logic                 mul_done;
	logic                 in_grid;
	logic [23:0]          new_idx;

	assign len36  = $signed({4'b0, len_q});
	assign hgt36  = $signed({4'b0, hgt_q});
	assign half36 = $signed({5'b0, len_q[31:1]});
	assign xa     = $signed({{4{x_pos[31]}}, x_pos}) - $signed({{4{ox_q[31]}}, ox_q});
	assign y0     = $signed({{4{y_pos[31]}}, y_pos}) - $signed({{4{oy_q[31]}}, oy_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 32'd65536;
			hgt_q <= 32'd56756;
			ox_q  <= '0;
			oy_q  <= '0;
			gw_q  <= 13'd256;
			gh_q  <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EDGE:   len_q <= cfg_data;
				REG_HEIGHT: hgt_q <= cfg_data;
				REG_ORG_X:  ox_q  <= cfg_data;
				REG_ORG_Y:  oy_q  <= cfg_data;
				REG_GRID_W: gw_q  <= cfg_data[12:0];
				REG_GRID_H: gh_q  <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	// corners and payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q <= xa;
			bx_q <= xa + len36;
			cx_q <= xa + half36;
			if (orientation == ORIENT_UP) begin
				ay_q <= y0;
				by_q <= y0;
				cy_q <= y0 + hgt36;
			end else begin
				ay_q <= y0 - hgt36;
				by_q <= y0;
				cy_q <= y0;
			end
			ea_q   <= euler_a;
			eb_q   <= euler_b;
			ec_q   <= euler_c;
			conf_q <= confidence;
			qual_q <= quality_good;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (cmd.capture) begin
			ok_q <= (orientation == ORIENT_UP || orientation == ORIENT_DOWN) && len_q != '0;
		end
	end

	always_comb begin
		unique case (cmd.div_sel)
			DSEL_XA: div_num = ax_q;
			DSEL_XB: div_num = bx_q;
			DSEL_YA: div_num = ay_q;
			default: div_num = cy_q;
		endcase
	end

	tcgr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (div_num),
		.den    (len_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			unique case (cmd.div_sel)
				DSEL_XA: j0_q <= div_quo;
				DSEL_XB: j1_q <= div_quo;
				DSEL_YA: k0_q <= div_quo;
				default: k1_q <= div_quo;
			endcase
		end
	end

	// edge from u to v
	always_comb begin
		unique case (cmd.edge_sel)
			EDGE_BA: begin
				ux = bx_q; uy = by_q; vx = ax_q; vy = ay_q;
			end
			EDGE_CB: begin
				ux = cx_q; uy = cy_q; vx = bx_q; vy = by_q;
			end
			default: begin
				ux = ax_q; uy = ay_q; vx = cx_q; vy = cy_q;
			end
		endcase
	end

	always_comb begin
		unique case (cmd.mul_op)
			MOP_PX: begin
				mul_a = j0_q; mul_b = len36;
			end
			MOP_PY: begin
				mul_a = k0_q; mul_b = len36;
			end
			MOP_E1: begin
				mul_a = px_q - ux; mul_b = vy - uy;
			end
			default: begin
				mul_a = vx - ux; mul_b = py_q - uy;
			end
		endcase
	end

	tcgr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign d  = p1_q - mul_p;
	assign nd = -d;

	always_ff @(posedge clk) begin
		if (mul_done) begin
			unique case (cmd.mul_op)
				MOP_PX: px0_q <= mul_p[CW-1:0];
				MOP_PY: py0_q <= mul_p[CW-1:0];
				MOP_E1: p1_q  <= mul_p;
				default: begin
					// sign after truncation toward zero to whole units
					if (!d[PW-1] && (|d[PW-1:32]))
						pos_q <= 1'b1;
					if (d[PW-1] && (|nd[PW-1:32]))
						neg_q <= 1'b1;
				end
			endcase
		end
		if (cmd.cell_init) begin
			px_q  <= px0_q + (cmd.jo ? len36 : '0);
			py_q  <= py0_q + (cmd.ko ? len36 : '0);
			col_q <= j0_q + CW'(cmd.jo);
			row_q <= k0_q + CW'(cmd.ko);
			pos_q <= 1'b0;
			neg_q <= 1'b0;
		end
	end

	assign in_grid = !col_q[CW-1] && !row_q[CW-1]
		&& ($unsigned(col_q) < CW'(gw_q)) && ($unsigned(col_q) < CW'(MAX_COLS))
		&& ($unsigned(row_q) < CW'(gh_q)) && ($unsigned(row_q) < CW'(MAX_ROWS));

	assign new_idx = 24'(row_q[23:0] * gw_q) + col_q[23:0];

	// one covered cell is held back so that the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			if (cmd.push) begin
				valid_q  <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				valid_q  <= pend_v_q;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.flush) begin
			idx_q     <= pend_idx_q;
			col_out_q <= pend_col_q;
			row_out_q <= pend_row_q;
			last_q    <= cmd.flush;
		end
		if (cmd.push) begin
			pend_idx_q <= new_idx;
			pend_col_q <= col_q[11:0];
			pend_row_q <= row_q[11:0];
		end
	end

	assign stat.ok       = ok_q;
	assign stat.div_done = div_done;
	assign stat.mul_done = mul_done;
	assign stat.jspan    = j1_q != j0_q;
	assign stat.kspan    = k1_q != k0_q;
	assign stat.hit      = !(pos_q && neg_q) && in_grid;

	assign valid          = valid_q;
	assign cell_index     = idx_q;
	assign column         = col_out_q;
	assign row            = row_out_q;
	assign out_euler_a    = ea_q;
	assign out_euler_b    = eb_q;
	assign out_euler_c    = ec_q;
	assign out_confidence = conf_q;
	assign out_quality    = qual_q;
	assign last           = last_q;

endmodule

// ===== rtl/tcgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Sequencer: four divisions for the bounding box, two products for the
// first cell corner, then the edge functions of each cell, for up to four cells.
// ----------------------------------------------------------------------------
module tcgr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output tcgr_pkg::cmd_t  cmd,
	input  tcgr_pkg::stat_t stat
);
	import tcgr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIV_GO,
		S_DIV_WAIT,
		S_PX_GO,
		S_PX_WAIT,
		S_PY_GO,
		S_PY_WAIT,
		S_CELL,
		S_E1_GO,
		S_E1_WAIT,
		S_E2_GO,
		S_E2_WAIT,
		S_JUDGE,
		S_FLUSH
	} state_t;

	state_t     state_q;
	logic [1:0] dsel_q;
	logic [1:0] edge_q;
	logic       jo_q;
	logic       ko_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dsel_q  <= DSEL_XA;
			edge_q  <= EDGE_BA;
			jo_q    <= 1'b0;
			ko_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					dsel_q  <= DSEL_XA;
					state_q <= stat.ok ? S_DIV_GO : S_IDLE;
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						if (dsel_q == DSEL_YC) begin
							state_q <= S_PX_GO;
						end else begin
							dsel_q  <= dsel_q + 2'd1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_PX_GO: begin
					jo_q    <= 1'b0;
					ko_q    <= 1'b0;
					state_q <= S_PX_WAIT;
				end
				S_PX_WAIT: begin
					if (stat.mul_done)
						state_q <= S_PY_GO;
				end
				S_PY_GO: state_q <= S_PY_WAIT;
				S_PY_WAIT: begin
					if (stat.mul_done)
						state_q <= S_CELL;
				end
				S_CELL: begin
					edge_q  <= EDGE_BA;
					state_q <= S_E1_GO;
				end
				S_E1_GO: state_q <= S_E1_WAIT;
				S_E1_WAIT: begin
					if (stat.mul_done)
						state_q <= S_E2_GO;
				end
				S_E2_GO: state_q <= S_E2_WAIT;
				S_E2_WAIT: begin
					if (stat.mul_done) begin
						if (edge_q == EDGE_AC) begin
							state_q <= S_JUDGE;
						end else begin
							edge_q  <= edge_q + 2'd1;
							state_q <= S_E1_GO;
						end
					end
				end
				S_JUDGE: begin
					// rows inner, columns outer
					priority if (!ko_q && stat.kspan) begin
						ko_q    <= 1'b1;
						state_q <= S_CELL;
					end else if (!jo_q && stat.jspan) begin
						jo_q    <= 1'b1;
						ko_q    <= 1'b0;
						state_q <= S_CELL;
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && start;
		cmd.div_sel   = dsel_q;
		cmd.div_go    = state_q == S_DIV_GO;
		cmd.edge_sel  = edge_q;
		cmd.jo        = jo_q;
		cmd.ko        = ko_q;
		cmd.cell_init = state_q == S_CELL;
		cmd.push      = (state_q == S_JUDGE) && stat.hit;
		cmd.flush     = state_q == S_FLUSH;
		unique case (state_q)
			S_PX_GO, S_PX_WAIT: cmd.mul_op = MOP_PX;
			S_PY_GO, S_PY_WAIT: cmd.mul_op = MOP_PY;
			S_E1_GO, S_E1_WAIT: cmd.mul_op = MOP_E1;
			default:            cmd.mul_op = MOP_E2;
		endcase
		cmd.mul_go = state_q == S_PX_GO || state_q == S_PY_GO
			|| state_q == S_E1_GO || state_q == S_E2_GO;
	end

	assign busy = state_q != S_IDLE;

endmodule
